FILE: design/ftu_pkg.sv
// fire texture update: shared types, constants and the cooling function
// no dependencies; used by ftu_ctrl and the top level
package ftu_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_PASS,
    ST_FLUSH
  } state_e;

  localparam logic [7:0] HOT_RESET = 8'd191;
  localparam logic       MODE_STEP = 1'b0;
  localparam logic       MODE_READ = 1'b1;

  typedef struct packed {
    logic grid;
    logic feed;
    logic noise;
    logic line;
  } mem_we_t;

  // average of self and three lower neighbors, then decay by one
  function automatic logic [7:0] cool(input logic [7:0] self_v, input logic [7:0] l_v,
                                      input logic [7:0] c_v, input logic [7:0] r_v);
    logic [9:0] sum;
    logic [7:0] q;
    sum = {2'b00, self_v} + {2'b00, l_v} + {2'b00, c_v} + {2'b00, r_v};
    q = sum[9:2];
    return (q != 8'd0) ? q - 8'd1 : q;
  endfunction

endpackage

FILE: design/ftu_ram.sv
// generic single write, single read synchronous ram with registered read data
// no dependencies
module ftu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ftu_noise_gen.sv
// five-stage running-sum noise generator, skewed one stage per cycle
// no package dependencies; driven by the fill counter of ftu_ctrl
module ftu_noise_gen #(
  parameter int GRID_SIZE = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             run_i,
  input  logic [$clog2(GRID_SIZE+6)-1:0]   pos_i,
  output logic                             noise_bit_o
);

  localparam int CW = $clog2(GRID_SIZE + 6);

  logic [15:0] gen_q [5];
  logic [4:0]  en;

  // stage i advances while the fill position is in i .. GRID_SIZE+i-1
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      en[i] = run_i && (pos_i >= CW'(i)) && (pos_i < CW'(GRID_SIZE + i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        gen_q[i] <= 16'd0;
      end
    end else begin
      if (en[0]) begin
        gen_q[0] <= gen_q[0] + 16'd1;
      end
      for (int i = 1; i < 5; i++) begin
        if (en[i]) begin
          gen_q[i] <= gen_q[i] + gen_q[i-1];
        end
      end
    end
  end

  assign noise_bit_o = ^gen_q[4];

endmodule

FILE: design/ftu_ctrl.sv
// fire texture update sequencer: clear sweep, texel reads, noise fill and
// row-by-row read-modify-write passes; depends on ftu_pkg
module ftu_ctrl #(
  parameter int GRID_SIZE = 64
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    mode_i,
  input  logic [5:0]                              read_x_i,
  input  logic [5:0]                              read_y_i,
  output logic [7:0]                              texel_o,
  output logic                                    done_o,
  input  logic [7:0]                              hot_i,
  input  logic                                    noise_bit_i,
  output logic                                    fill_run_o,
  output logic [$clog2(GRID_SIZE+6)-1:0]          fill_pos_o,
  output ftu_pkg::mem_we_t                        we_o,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]  grid_waddr_o,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]  grid_raddr_o,
  output logic [$clog2(GRID_SIZE)-1:0]            feed_waddr_o,
  output logic [$clog2(GRID_SIZE)-1:0]            noise_waddr_o,
  output logic [$clog2(GRID_SIZE)-1:0]            line_waddr_o,
  output logic [$clog2(GRID_SIZE)-1:0]            below_raddr_o,
  output logic [$clog2(GRID_SIZE)-1:0]            line_raddr_o,
  output logic [7:0]                              grid_wdata_o,
  output logic [7:0]                              feed_wdata_o,
  output logic [7:0]                              noise_wdata_o,
  output logic [7:0]                              line_wdata_o,
  input  logic [7:0]                              grid_rdata_i,
  input  logic [7:0]                              feed_rdata_i,
  input  logic [7:0]                              noise_rdata_i,
  input  logic [7:0]                              line_rdata_i
);

  localparam int XW = $clog2(GRID_SIZE);
  localparam int RW = $clog2(GRID_SIZE + 1);
  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int CW = $clog2(GRID_SIZE + 6);

  localparam logic [CW-1:0] POS_LAST_FILL = CW'(GRID_SIZE + 4);
  localparam logic [CW-1:0] POS_LAST_PASS = CW'(GRID_SIZE + 1);
  localparam logic [CW-1:0] POS_NOISE     = CW'(5);
  localparam logic [CW-1:0] POS_GRID      = CW'(GRID_SIZE);
  localparam logic [CW-1:0] POS_SELF      = CW'(2);
  localparam logic [RW-1:0] ROW_FEED      = RW'(GRID_SIZE - 1);
  localparam logic [RW-1:0] ROW_LAST      = RW'(GRID_SIZE);
  localparam logic [AW-1:0] CLR_LAST      = AW'(GRID_SIZE * GRID_SIZE - 1);
  localparam logic [AW-1:0] CLR_FEED      = AW'(GRID_SIZE);
  localparam logic [AW-1:0] GRID_STRIDE   = AW'(GRID_SIZE);

  // coordinate modulo the grid size by conditional subtraction
  function automatic logic [XW-1:0] fold(input logic [5:0] v);
    logic [8:0] w;
    w = {3'b000, v};
    for (int i = 0; i < 8; i++) begin
      if (w >= 9'(GRID_SIZE)) begin
        w = w - 9'(GRID_SIZE);
      end
    end
    return w[XW-1:0];
  endfunction

  ftu_pkg::state_e state_q, state_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [RW-1:0]   row_q, row_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            done_q, done_d;
  logic [7:0]      texel_q, texel_d;

  logic            s1_vld_q, s1_vld_d;
  logic            s1_fill_q, s1_fill_d;
  logic [CW-1:0]   s1_pos_q;
  logic [RW-1:0]   s1_row_q;
  logic [7:0]      win_a_q, win_b_q;

  logic [XW-1:0]   below_idx;
  logic [XW-1:0]   s1_x;
  logic [7:0]      below;
  logic [7:0]      cooled;
  logic [AW-1:0]   read_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ftu_pkg::ST_CLEAR;
      pos_q     <= '0;
      row_q     <= '0;
      clr_q     <= '0;
      done_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_fill_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      row_q     <= row_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
      s1_vld_q  <= s1_vld_d;
      s1_fill_q <= s1_fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    texel_q  <= texel_d;
    s1_pos_q <= pos_q;
    s1_row_q <= row_q;
    if (s1_vld_q && !s1_fill_q) begin
      win_a_q <= win_b_q;
      win_b_q <= below;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ftu_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ftu_pkg::ST_IDLE;
      end
      ftu_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (mode_i == ftu_pkg::MODE_READ) ? ftu_pkg::ST_READ : ftu_pkg::ST_FILL;
        end
      end
      ftu_pkg::ST_READ: state_d = ftu_pkg::ST_IDLE;
      ftu_pkg::ST_FILL: begin
        if (pos_q == POS_LAST_FILL) state_d = ftu_pkg::ST_PASS;
      end
      ftu_pkg::ST_PASS: begin
        if (pos_q == POS_LAST_PASS && row_q == ROW_LAST) state_d = ftu_pkg::ST_FLUSH;
      end
      ftu_pkg::ST_FLUSH: state_d = ftu_pkg::ST_IDLE;
      default: state_d = ftu_pkg::ST_IDLE;
    endcase
  end

  // lower-row index: wrap-in column, the row, then wrap-out column
  always_comb begin
    if (pos_q == '0) begin
      below_idx = XW'(GRID_SIZE - 1);
    end else if (pos_q == POS_LAST_PASS) begin
      below_idx = '0;
    end else begin
      below_idx = XW'(pos_q - CW'(1));
    end
  end

  assign read_addr = AW'(fold(read_y_i)) * GRID_STRIDE + AW'(fold(read_x_i));
  assign s1_x      = XW'(s1_pos_q - POS_SELF);

  always_comb begin
    if (s1_row_q == ROW_LAST) begin
      below = noise_rdata_i;
    end else if (s1_row_q == ROW_FEED) begin
      below = feed_rdata_i;
    end else begin
      below = grid_rdata_i;
    end
  end

  assign cooled = ftu_pkg::cool(line_rdata_i, win_a_q, win_b_q, below);

  // outputs and counters
  always_comb begin
    pos_d         = pos_q;
    row_d         = row_q;
    clr_d         = clr_q;
    done_d        = 1'b0;
    texel_d       = texel_q;
    s1_vld_d      = 1'b0;
    s1_fill_d     = 1'b0;
    busy          = 1'b1;
    fill_run_o    = 1'b0;
    we_o          = '0;
    grid_raddr_o  = (AW'(row_q) + AW'(1)) * GRID_STRIDE + AW'(below_idx);
    grid_waddr_o  = AW'(s1_row_q) * GRID_STRIDE + AW'(s1_x);
    grid_wdata_o  = cooled;
    feed_waddr_o  = s1_x;
    feed_wdata_o  = cooled;
    noise_waddr_o = XW'(pos_q - POS_NOISE);
    noise_wdata_o = noise_bit_i ? hot_i : 8'd0;
    line_waddr_o  = s1_x;
    line_wdata_o  = win_b_q;
    case (state_q)
      ftu_pkg::ST_CLEAR: begin
        clr_d        = clr_q + AW'(1);
        we_o.grid    = 1'b1;
        grid_waddr_o = clr_q;
        grid_wdata_o = 8'd0;
        we_o.feed    = (clr_q < CLR_FEED);
        feed_waddr_o = XW'(clr_q);
        feed_wdata_o = 8'd0;
      end
      ftu_pkg::ST_IDLE: begin
        busy         = 1'b0;
        pos_d        = '0;
        row_d        = '0;
        grid_raddr_o = read_addr;
      end
      ftu_pkg::ST_READ: begin
        done_d  = 1'b1;
        texel_d = grid_rdata_i;
      end
      ftu_pkg::ST_FILL: begin
        fill_run_o   = 1'b1;
        s1_vld_d     = 1'b1;
        s1_fill_d    = 1'b1;
        grid_raddr_o = AW'(pos_q);
        we_o.noise   = (pos_q >= POS_NOISE);
        pos_d        = (pos_q == POS_LAST_FILL) ? '0 : pos_q + CW'(1);
      end
      ftu_pkg::ST_PASS: begin
        s1_vld_d = 1'b1;
        if (pos_q == POS_LAST_PASS) begin
          pos_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end
      ftu_pkg::ST_FLUSH: begin
        done_d  = 1'b1;
        texel_d = 8'd0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase

    // second stage: capture the top row, or write back one cooled texel and keep the old lower-row value
    if (s1_vld_q && s1_fill_q) begin
      we_o.line    = (s1_pos_q < POS_GRID);
      line_waddr_o = XW'(s1_pos_q);
      line_wdata_o = grid_rdata_i;
    end else if (s1_vld_q && s1_pos_q >= POS_SELF) begin
      we_o.line = 1'b1;
      if (s1_row_q == ROW_LAST) begin
        we_o.feed = 1'b1;
      end else begin
        we_o.grid = 1'b1;
      end
    end
  end

  assign below_raddr_o = below_idx;
  assign line_raddr_o  = XW'(pos_q - POS_SELF);
  assign fill_pos_o    = pos_q;
  assign done_o        = done_q;
  assign texel_o       = texel_q;

endmodule

FILE: design/fire_texture_update_top.sv
// fire texture update top level: configuration register, state memories,
// noise generator and sequencer; depends on ftu_pkg, ftu_ram, ftu_noise_gen, ftu_ctrl
//
// A transaction is taken when start is high and busy is low; its single result
// appears on texel_o for exactly one cycle with done_o high and cannot be held
// off. A read holds busy high in the READ state, where the texel read from the
// texture memory is registered onto texel_o. A step returns zero; the texture
// memory has a single read port, so a step reads one texel and writes one per
// cycle, with two extra reads per row for the wrapping neighbors and a noise fill
// pass up front. After reset the block sweeps the texture to zero with busy high;
// hot_value writes are taken at any time.
module fire_texture_update_top #(
  parameter int GRID_SIZE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       mode_i,
  input  logic [5:0] read_x_i,
  input  logic [5:0] read_y_i,
  output logic [7:0] texel_o,
  output logic       done_o,
  input  logic       hot_value_we_i,
  input  logic [7:0] hot_value_i
);

  localparam int XW = $clog2(GRID_SIZE);
  localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int CW = $clog2(GRID_SIZE + 6);

  logic [7:0]       hot_q;
  logic             noise_bit;
  logic             fill_run;
  logic [CW-1:0]    fill_pos;
  ftu_pkg::mem_we_t we;
  logic [AW-1:0]    grid_waddr, grid_raddr;
  logic [XW-1:0]    feed_waddr, noise_waddr, line_waddr, below_raddr, line_raddr;
  logic [7:0]       grid_wdata, feed_wdata, noise_wdata, line_wdata;
  logic [7:0]       grid_rdata, feed_rdata, noise_rdata, line_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hot_q <= ftu_pkg::HOT_RESET;
    end else if (hot_value_we_i) begin
      hot_q <= hot_value_i;
    end
  end

  ftu_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .read_x_i      (read_x_i),
    .read_y_i      (read_y_i),
    .texel_o       (texel_o),
    .done_o        (done_o),
    .hot_i         (hot_q),
    .noise_bit_i   (noise_bit),
    .fill_run_o    (fill_run),
    .fill_pos_o    (fill_pos),
    .we_o          (we),
    .grid_waddr_o  (grid_waddr),
    .grid_raddr_o  (grid_raddr),
    .feed_waddr_o  (feed_waddr),
    .noise_waddr_o (noise_waddr),
    .line_waddr_o  (line_waddr),
    .below_raddr_o (below_raddr),
    .line_raddr_o  (line_raddr),
    .grid_wdata_o  (grid_wdata),
    .feed_wdata_o  (feed_wdata),
    .noise_wdata_o (noise_wdata),
    .line_wdata_o  (line_wdata),
    .grid_rdata_i  (grid_rdata),
    .feed_rdata_i  (feed_rdata),
    .noise_rdata_i (noise_rdata),
    .line_rdata_i  (line_rdata)
  );

  ftu_noise_gen #(.GRID_SIZE(GRID_SIZE)) u_noise_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (fill_run),
    .pos_i       (fill_pos),
    .noise_bit_o (noise_bit)
  );

  ftu_ram #(.WIDTH(8), .DEPTH(GRID_SIZE * GRID_SIZE)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (we.grid),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  ftu_ram #(.WIDTH(8), .DEPTH(GRID_SIZE)) u_feed_ram (
    .clk_i   (clk_i),
    .we_i    (we.feed),
    .waddr_i (feed_waddr),
    .wdata_i (feed_wdata),
    .raddr_i (below_raddr),
    .rdata_o (feed_rdata)
  );

  ftu_ram #(.WIDTH(8), .DEPTH(GRID_SIZE)) u_noise_ram (
    .clk_i   (clk_i),
    .we_i    (we.noise),
    .waddr_i (noise_waddr),
    .wdata_i (noise_wdata),
    .raddr_i (below_raddr),
    .rdata_o (noise_rdata)
  );

  // holds the current row's old values, saved during the pass above it, used as each texel's own value
  ftu_ram #(.WIDTH(8), .DEPTH(GRID_SIZE)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we.line),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

endmodule

FILE: design/ftu_checker.sv
// port-level checks for the fire texture update block, bound to the top level
// depends only on the ports of fire_texture_update_top
module ftu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic mode_i,
  input logic done_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i) |-> ##2 done_o)
    else $error("read result not returned two cycles after acceptance");

endmodule

bind fire_texture_update_top ftu_checker u_ftu_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .mode_i (mode_i),
  .done_o (done_o)
);
